FILE: hdl/wrrc_pkg.sv
// ----------------------------------------------------------------------------
// wrrc_pkg: shared types and constants of the windowed residual rank counter
// Item layouts, operation codes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package wrrc_pkg;

  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned RES_W   = 32;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned OUT_W   = 13;
  localparam int unsigned PROD_W  = TOTAL_W + TOL_W;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd32768;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic [TOTAL_W-1:0] total;
    logic [RES_W-1:0]   residual;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] above_count;
    logic [OUT_W-1:0] window_count;
  } out_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [RES_W-1:0]   residual;
  } point_t;

  typedef struct packed {
    logic start_query;
    logic issue;
  } scan_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/wrrc_mem.sv
// ----------------------------------------------------------------------------
// wrrc_mem: point store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wrrc_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  wrrc_pkg::point_t  wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output wrrc_pkg::point_t  rdata_o
);
  import wrrc_pkg::*;

  point_t mem_q [DEPTH];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/wrrc_scan.sv
// ----------------------------------------------------------------------------
// wrrc_scan: window test and counting datapath
// One shared 32x16 multiplier forms the lower bound once per query and then
// one scaled stored total per cycle; a compare stage updates the counters.
// ----------------------------------------------------------------------------
`default_nettype none

module wrrc_scan #(
  parameter int unsigned CNT_W = 13
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wrrc_pkg::scan_ctrl_t        ctrl_i,
  input  wrrc_pkg::in_t               obs_i,
  input  logic [wrrc_pkg::TOL_W-1:0]  tol_i,
  input  wrrc_pkg::point_t            rd_i,
  output logic                        pipe_busy_o,
  output logic [CNT_W-1:0]            above_o,
  output logic [CNT_W-1:0]            window_o
);
  import wrrc_pkg::*;

  logic [TOTAL_W-1:0] mul_a;
  logic [PROD_W-1:0]  mul_p;
  logic [PROD_W-1:0]  lower_q, prod_q;
  logic [TOTAL_W-1:0] s_q;
  logic [RES_W-1:0]   r_q;
  logic               v1_q, v2_q;
  logic               in_win, is_above;
  logic [CNT_W-1:0]   above_q, window_q;

  assign mul_a = ctrl_i.start_query ? obs_i.total : rd_i.total;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(tol_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start_query) begin
      lower_q <= mul_p;
    end
    prod_q <= mul_p;
    s_q    <= rd_i.total;
    r_q    <= rd_i.residual;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.issue;
      v2_q <= v1_q;
    end
  end

  assign in_win   = (lower_q <= {s_q, {TOL_W{1'b0}}}) &&
                    (prod_q < {obs_i.total, {TOL_W{1'b0}}});
  assign is_above = $signed(r_q) >= $signed(obs_i.residual);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q  <= '0;
      window_q <= '0;
    end else if (ctrl_i.start_query) begin
      above_q  <= '0;
      window_q <= '0;
    end else if (v2_q && in_win) begin
      window_q <= window_q + CNT_W'(1);
      if (is_above) begin
        above_q <= above_q + CNT_W'(1);
      end
    end
  end

  assign pipe_busy_o = v1_q | v2_q;
  assign above_o     = above_q;
  assign window_o    = window_q;

endmodule

`default_nettype wire

FILE: hdl/windowed_residual_rank_counter_core.sv
// ----------------------------------------------------------------------------
// windowed_residual_rank_counter_core: windowed residual rank counter
// Stores (total, residual) points and, for each query, counts the stored
// points in the tolerance window and, among them, those with a residual at
// least the observed one.
//
//   Channel   Direction  Signals
//   item      in         start, busy, item_i
//   result    out        done_o, result_o
//   config    in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Clear and load items never raise busy.
// A query raises busy from S_LOWER through S_SCAN to the end of S_DRAIN,
// and done_o pulses in the last cycle that busy is high.
// The single read port of the store sets the scan rate of one point per cycle.
// Reset empties the store and sets the tolerance to one half.
// The receiver takes every result in the cycle that done_o is high.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_residual_rank_counter_core #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  wrrc_pkg::in_t         item_i,
  output logic                  done_o,
  output wrrc_pkg::out_t        result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import wrrc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW    = $clog2(MAX_POINTS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOWER = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  in_t              obs_q, obs_d;
  logic [TOL_W-1:0] tol_q;
  logic             mem_we;
  point_t           wpoint, rpoint;
  scan_ctrl_t       scan_ctrl;
  logic             pipe_busy;
  logic [CNT_W-1:0] above_cnt, window_cnt;
  logic             full;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, tol_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      tol_q <= pwdata[TOL_W-1:0];
    end
  end

  // Sequencer.
  assign full = (count_q == CNT_W'(MAX_POINTS));

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    obs_d   = obs_q;
    mem_we  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (item_i.operation)
            OP_CLEAR: count_d = '0;
            OP_LOAD: begin
              if (!full) begin
                mem_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_QUERY: begin
              obs_d   = item_i;
              state_d = S_LOWER;
            end
            default: ;
          endcase
        end
      end
      S_LOWER: begin
        idx_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (idx_q == count_q) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obs_q <= obs_d;
  end

  assign busy                  = (state_q != S_IDLE);
  assign scan_ctrl.start_query = (state_q == S_LOWER);
  assign scan_ctrl.issue       = (state_q == S_SCAN) && (idx_q != count_q);

  assign wpoint.total    = item_i.total;
  assign wpoint.residual = item_i.residual;

  wrrc_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wpoint),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rpoint)
  );

  wrrc_scan #(
    .CNT_W (CNT_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .obs_i       (obs_q),
    .tol_i       (tol_q),
    .rd_i        (rpoint),
    .pipe_busy_o (pipe_busy),
    .above_o     (above_cnt),
    .window_o    (window_cnt)
  );

  assign done_o                = (state_q == S_DRAIN) && !pipe_busy;
  assign result_o.above_count  = OUT_W'(above_cnt);
  assign result_o.window_count = OUT_W'(window_cnt);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count exceeds capacity");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= count_q || state_q == S_IDLE || state_q == S_LOWER)
    else $error("scan index passed the point count");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> state_q == S_IDLE)
    else $error("sequencer did not return to idle after a result");

  a_query_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.operation == OP_QUERY) |=> state_q == S_LOWER)
    else $error("query item did not start a scan");

  a_above_le_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> above_cnt <= window_cnt)
    else $error("above count exceeds window count");

endmodule

`default_nettype wire
